>>> design/tlpt_pkg.sv
// ----------------------------------------------------------------------------
// Page table update package
// Shared constants, field layouts and transaction types of the two-level
// page table update block.
// ----------------------------------------------------------------------------
package tlpt_pkg;

    localparam int TABLE_SLOTS = 16;

    localparam int IDX_W      = 10;
    localparam int OFFSET_W   = 12;
    localparam int ADDR_W     = 32;
    localparam int FRAME_W    = 20;
    localparam int PAGE_W     = 20;
    localparam int DIR_DEPTH  = 1 << IDX_W;

    localparam int SLOT_W     = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int NF_W       = $clog2(TABLE_SLOTS + 1);
    localparam int TAB_DEPTH  = TABLE_SLOTS * DIR_DEPTH;
    localparam int TAB_AW     = $clog2(TAB_DEPTH);
    localparam int CLR_W      = TAB_AW + 1;
    localparam int DIR_W      = SLOT_W + 1;
    localparam int PTE_W      = FRAME_W + 2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DIRECTORY_READY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGING_ON       = 2'd1;

    localparam logic OP_MAP   = 1'b0;
    localparam logic OP_UNMAP = 1'b1;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] vaddr;
        logic [ADDR_W-1:0] paddr;
        logic              writable;
    } req_t;

    typedef struct packed {
        logic              ok;
        logic              invalidate;
        logic [PAGE_W-1:0] invalidate_page;
    } rsp_t;

    typedef struct packed {
        logic               op;
        logic               early_fail;
        logic [IDX_W-1:0]   dir_idx;
        logic [IDX_W-1:0]   tab_idx;
        logic [FRAME_W-1:0] frame;
        logic               writable;
    } item_t;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
    } dir_ent_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic               writable;
        logic               present;
    } pte_t;

endpackage

>>> design/tlpt_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module tlpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/tlpt_front.sv
// ----------------------------------------------------------------------------
// Page table update front end
// Accepts request transactions, checks alignment and directory readiness,
// and splits the addresses into directory index, table index and frame.
// ----------------------------------------------------------------------------
module tlpt_front (
    input  logic           req_valid,
    output logic           req_stall,
    input  tlpt_pkg::req_t req,
    input  logic           directory_ready,
    input  logic           clearing,
    input  logic           q_full,
    output logic           push,
    output tlpt_pkg::item_t push_item
);

    logic va_misaligned;
    logic pa_misaligned;

    assign va_misaligned = |req.vaddr[tlpt_pkg::OFFSET_W-1:0];
    assign pa_misaligned = |req.paddr[tlpt_pkg::OFFSET_W-1:0];

    assign req_stall = q_full || clearing;
    assign push      = req_valid && !req_stall;

    always_comb
    begin
        push_item.op         = req.op;
        push_item.early_fail = va_misaligned || !directory_ready ||
                               (req.op == tlpt_pkg::OP_MAP && pa_misaligned);
        push_item.dir_idx    = req.vaddr[31:22];
        push_item.tab_idx    = req.vaddr[21:12];
        push_item.frame      = req.paddr[31:12];
        push_item.writable   = req.writable;
    end

endmodule

>>> design/tlpt_queue.sv
// ----------------------------------------------------------------------------
// Page table update queue
// Short FIFO of classified items between the front end and the back end.
// ----------------------------------------------------------------------------
module tlpt_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tlpt_pkg::item_t push_item,
    input  logic            pop,
    output tlpt_pkg::item_t head,
    output logic            full,
    output logic            empty
);

    tlpt_pkg::item_t                    slots_reg [tlpt_pkg::QUEUE_DEPTH];
    logic [tlpt_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [tlpt_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [tlpt_pkg::QCNT_W-1:0]        count_reg;
    logic [tlpt_pkg::QCNT_W-1:0]        count_next;

    assign full  = (count_reg == tlpt_pkg::QCNT_W'(tlpt_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> design/tlpt_back.sv
// ----------------------------------------------------------------------------
// Page table update back end
// Initialises directory and table store after reset; walks checked items
// through directory read, table read and write back; holds the response.
// ----------------------------------------------------------------------------
module tlpt_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            paging_on,
    input  logic            q_empty,
    input  tlpt_pkg::item_t head,
    output logic            pop,
    output logic            clearing,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output tlpt_pkg::rsp_t  rsp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIR  = 2'd1;
    localparam logic [1:0] S_TAB  = 2'd2;

    logic [1:0]                  state_reg;
    logic [1:0]                  state_next;
    tlpt_pkg::item_t             item_reg;
    tlpt_pkg::item_t             item_next;
    logic [tlpt_pkg::SLOT_W-1:0] slot_reg;
    logic [tlpt_pkg::SLOT_W-1:0] slot_next;
    logic [tlpt_pkg::NF_W-1:0]   next_free_reg;
    logic [tlpt_pkg::NF_W-1:0]   next_free_next;
    logic                        clear_busy_reg;
    logic [tlpt_pkg::CLR_W-1:0]  clear_cnt_reg;
    logic                        rsp_valid_reg;
    logic                        rsp_valid_next;
    tlpt_pkg::rsp_t              rsp_reg;
    tlpt_pkg::rsp_t              rsp_next;

    logic                        dir_re;
    logic                        dir_we;
    logic [tlpt_pkg::IDX_W-1:0]  dir_waddr;
    logic [tlpt_pkg::DIR_W-1:0]  dir_wdata;
    logic [tlpt_pkg::DIR_W-1:0]  dir_rdata;
    logic                        dir_we_op;
    tlpt_pkg::dir_ent_t          dir_wdata_op;
    tlpt_pkg::dir_ent_t          dir_rd;
    tlpt_pkg::dir_ent_t          dir_clear;

    logic                        tab_re;
    logic                        tab_we;
    logic [tlpt_pkg::TAB_AW-1:0] tab_raddr;
    logic [tlpt_pkg::TAB_AW-1:0] tab_waddr;
    logic [tlpt_pkg::PTE_W-1:0]  tab_wdata;
    logic [tlpt_pkg::PTE_W-1:0]  tab_rdata;
    logic                        tab_we_op;
    tlpt_pkg::pte_t              tab_wdata_op;
    tlpt_pkg::pte_t              tab_rd;
    tlpt_pkg::pte_t              tab_clear;

    logic                        in_first_table;
    logic [tlpt_pkg::SLOT_W-1:0] slot_sel;
    logic                        go;
    logic                        finish;
    logic                        finish_ok;

    function automatic logic [tlpt_pkg::TAB_AW-1:0] tab_addr(
        input logic [tlpt_pkg::SLOT_W-1:0] slot,
        input logic [tlpt_pkg::IDX_W-1:0]  idx
    );
        logic [tlpt_pkg::SLOT_W+tlpt_pkg::IDX_W-1:0] full_addr;
        full_addr = {slot, idx};
        return full_addr[tlpt_pkg::TAB_AW-1:0];
    endfunction

    assign dir_rd   = tlpt_pkg::dir_ent_t'(dir_rdata);
    assign tab_rd   = tlpt_pkg::pte_t'(tab_rdata);
    assign clearing = clear_busy_reg;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_comb
    begin
        state_next     = state_reg;
        item_next      = item_reg;
        slot_next      = slot_reg;
        next_free_next = next_free_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        pop            = 1'b0;
        dir_re         = 1'b0;
        tab_re         = 1'b0;
        dir_we_op      = 1'b0;
        tab_we_op      = 1'b0;
        tab_wdata_op   = '0;
        go             = 1'b0;
        finish         = 1'b0;
        finish_ok      = 1'b0;
        slot_sel       = dir_rd.slot;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!clear_busy_reg && !q_empty && (!rsp_valid_reg || !rsp_stall))
                begin
                    pop       = 1'b1;
                    item_next = head;
                    if (head.early_fail)
                    begin
                        finish = 1'b1;
                    end
                    else
                    begin
                        dir_re     = 1'b1;
                        state_next = S_DIR;
                    end
                end
            end
            S_DIR:
            begin
                if (dir_rd.valid)
                begin
                    go = 1'b1;
                end
                else if (item_reg.op == tlpt_pkg::OP_MAP &&
                         next_free_reg < tlpt_pkg::NF_W'(tlpt_pkg::TABLE_SLOTS))
                begin
                    slot_sel       = next_free_reg[tlpt_pkg::SLOT_W-1:0];
                    next_free_next = tlpt_pkg::NF_W'(next_free_reg + 1'b1);
                    dir_we_op      = 1'b1;
                    go             = 1'b1;
                end
                if (go)
                begin
                    tab_re     = 1'b1;
                    slot_next  = slot_sel;
                    state_next = S_TAB;
                end
                else
                begin
                    finish     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_TAB:
            begin
                finish     = 1'b1;
                state_next = S_IDLE;
                if (item_reg.op == tlpt_pkg::OP_MAP)
                begin
                    if (!tab_rd.present)
                    begin
                        tab_we_op             = 1'b1;
                        tab_wdata_op.frame    = item_reg.frame;
                        tab_wdata_op.writable = item_reg.writable;
                        tab_wdata_op.present  = 1'b1;
                        finish_ok             = 1'b1;
                    end
                end
                else if (tab_rd.present)
                begin
                    tab_we_op = 1'b1;
                    finish_ok = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish)
        begin
            rsp_valid_next      = 1'b1;
            rsp_next.ok         = finish_ok;
            rsp_next.invalidate = finish_ok && paging_on;
            rsp_next.invalidate_page = (finish_ok && paging_on) ?
                                       {item_next.dir_idx, item_next.tab_idx} : '0;
        end
    end

    assign dir_wdata_op.valid = 1'b1;
    assign dir_wdata_op.slot  = slot_sel;

    assign in_first_table  = (clear_cnt_reg < tlpt_pkg::CLR_W'(tlpt_pkg::DIR_DEPTH));
    assign dir_clear.valid = (clear_cnt_reg == '0);
    assign dir_clear.slot  = '0;
    assign tab_clear.frame = in_first_table ?
                             tlpt_pkg::FRAME_W'(clear_cnt_reg[tlpt_pkg::IDX_W-1:0]) : '0;
    assign tab_clear.writable = in_first_table;
    assign tab_clear.present  = in_first_table;

    assign dir_we    = clear_busy_reg ? in_first_table : dir_we_op;
    assign dir_waddr = clear_busy_reg ? clear_cnt_reg[tlpt_pkg::IDX_W-1:0] : item_reg.dir_idx;
    assign dir_wdata = clear_busy_reg ? dir_clear : dir_wdata_op;

    assign tab_we    = clear_busy_reg || tab_we_op;
    assign tab_waddr = clear_busy_reg ? clear_cnt_reg[tlpt_pkg::TAB_AW-1:0] :
                       tab_addr(slot_reg, item_reg.tab_idx);
    assign tab_wdata = clear_busy_reg ? tab_clear : tab_wdata_op;
    assign tab_raddr = tab_addr(slot_sel, item_reg.tab_idx);

    tlpt_ram #(
        .WIDTH (tlpt_pkg::DIR_W),
        .DEPTH (tlpt_pkg::DIR_DEPTH)
    ) u_dir_ram (
        .clk   (clk),
        .we    (dir_we),
        .waddr (dir_waddr),
        .wdata (dir_wdata),
        .re    (dir_re),
        .raddr (head.dir_idx),
        .rdata (dir_rdata)
    );

    tlpt_ram #(
        .WIDTH (tlpt_pkg::PTE_W),
        .DEPTH (tlpt_pkg::TAB_DEPTH)
    ) u_tab_ram (
        .clk   (clk),
        .we    (tab_we),
        .waddr (tab_waddr),
        .wdata (tab_wdata),
        .re    (tab_re),
        .raddr (tab_raddr),
        .rdata (tab_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            next_free_reg  <= tlpt_pkg::NF_W'(1);
            clear_busy_reg <= 1'b1;
            clear_cnt_reg  <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            next_free_reg <= next_free_next;
            rsp_valid_reg <= rsp_valid_next;
            if (clear_busy_reg)
            begin
                if (clear_cnt_reg == tlpt_pkg::CLR_W'(tlpt_pkg::TAB_DEPTH - 1))
                begin
                    clear_busy_reg <= 1'b0;
                end
                clear_cnt_reg <= tlpt_pkg::CLR_W'(clear_cnt_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        slot_reg <= slot_next;
        rsp_reg  <= rsp_next;
    end

    a_busy_no_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !rsp_valid_reg)
        else $error("response pending while an item is in flight");

    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy_reg |-> (state_reg == S_IDLE && !tab_we_op && !dir_we_op))
        else $error("item processed during clearing pass");

    a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
        next_free_reg <= tlpt_pkg::NF_W'(tlpt_pkg::TABLE_SLOTS))
        else $error("slot pool overrun");

    a_inv_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (!rsp_reg.invalidate || rsp_reg.ok))
        else $error("invalidate without success");

    a_tab_after_dir: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_TAB |-> $past(state_reg) == S_DIR)
        else $error("table stage entered out of order");

endmodule

>>> design/two_level_page_table_update.sv
// ----------------------------------------------------------------------------
// Two-level page table update
// Maps and unmaps 4 KiB pages in a two-level table and reports the outcome.
// ----------------------------------------------------------------------------
// Sequencing: items that reach the table pass through directory read, table
//   read and write back in turn; items rejected by the alignment or
//   readiness checks are answered without any memory access.
// Overlap: the back end starts a new item only after the last one has
//   finished, since the directory and table memory reads are serial.
// Reset: a clearing pass over the TABLE_SLOTS * 1024 entries rewrites both
//   memories; req_stall stays high until it ends. Configuration is accepted.
module two_level_page_table_update (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_stall,
    input  tlpt_pkg::req_t                   req,
    output logic                             rsp_valid,
    input  logic                             rsp_stall,
    output tlpt_pkg::rsp_t                   rsp,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [tlpt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic                             cfg_data
);

    logic            directory_ready_reg;
    logic            paging_on_reg;
    logic            clearing;
    logic            q_full;
    logic            q_empty;
    logic            push;
    logic            pop;
    tlpt_pkg::item_t push_item;
    tlpt_pkg::item_t head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            directory_ready_reg <= 1'b0;
            paging_on_reg       <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tlpt_pkg::REG_DIRECTORY_READY: directory_ready_reg <= cfg_data;
                tlpt_pkg::REG_PAGING_ON:       paging_on_reg       <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    tlpt_front u_front (
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .req             (req),
        .directory_ready (directory_ready_reg),
        .clearing        (clearing),
        .q_full          (q_full),
        .push            (push),
        .push_item       (push_item)
    );

    tlpt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .full      (q_full),
        .empty     (q_empty)
    );

    tlpt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .paging_on (paging_on_reg),
        .q_empty   (q_empty),
        .head      (head),
        .pop       (pop),
        .clearing  (clearing),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
